// ===== hw/rtl/virtual_channel_queue_reserve_defines.svh =====
// assertion helpers for the virtual channel queue checker
`ifndef VIRTUAL_CHANNEL_QUEUE_RESERVE_DEFINES_SVH
`define VIRTUAL_CHANNEL_QUEUE_RESERVE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define VCQR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define VCQR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vcqr_pkg.sv =====
`timescale 1ns / 1ps
package vcqr_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RC_W   = $clog2(2 * DEPTH + 2);
    localparam int CH_W   = 8;
    localparam int ORD_W  = 16;
    localparam int CFG_W  = 5;
    localparam int CFGI_W = 2;

    localparam logic [1:0] OP_COMMIT  = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [CFGI_W-1:0] CFG_SLOTS = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SWAP  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MODE  = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_GUAR  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RSV_NO_ENQ  = 3'd1,
        ST_CAPACITY    = 3'd2,
        ST_RSV_REFUSED = 3'd3,
        ST_NOT_HELD    = 3'd4,
        ST_NOT_OFFERED = 3'd5,
        ST_TAIL_FULL   = 3'd6
    } t_status;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [ORD_W-1:0] tag;
        logic [ORD_W-1:0] node;
        logic [ORD_W-1:0] slot;
    } t_entry;

    typedef struct packed {
        logic [4:0]       pad;
        logic [CH_W-1:0]  deq_channel;
        logic [ORD_W-1:0] deq_tag;
        logic [ORD_W-1:0] deq_node;
        logic [ORD_W-1:0] deq_slot;
        logic             deq_valid;
        logic [ORD_W-1:0] enq_tag;
        logic [ORD_W-1:0] enq_node;
        logic [ORD_W-1:0] enq_slot;
        logic [CH_W-1:0]  channel;
        logic             enq_reserved;
        logic             enq_valid;
    } t_in_data;

    typedef struct packed {
        logic [3:0]       pad;
        logic [CNT_W-1:0] reserved_total;
        logic [CNT_W-1:0] occupancy;
        logic             enqueued;
        logic [CH_W-1:0]  out_channel;
        logic [ORD_W-1:0] out_tag;
        logic [ORD_W-1:0] out_node;
        logic [ORD_W-1:0] out_slot;
        logic             dequeued_valid;
    } t_out_data;

    localparam int IN_TDATA_W  = $bits(t_in_data);
    localparam int OUT_TDATA_W = $bits(t_out_data);

    typedef struct packed {
        logic    capture;
        logic    scan;
        logic    hold_dec;
        logic    hold_inc;
        logic    deq;
        logic    shift;
        logic    append;
        logic    load_out;
        t_status status;
        logic    did_deq;
        logic    did_enq;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       enq_valid;
        logic       enq_reserved;
        logic       deq_valid;
        logic       scan_last;
        logic       empty;
        logic       full;
        logic       claim_ok;
        logic       hold_found;
        logic       free_found;
        logic       offer_match;
        logic       holds_zero;
        logic       swap_ok;
        logic       shift_more;
    } t_stat;

endpackage

// ===== hw/rtl/vcqr_ctrl.sv =====
`timescale 1ns / 1ps
module vcqr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  vcqr_pkg::t_stat i_stat,
    output vcqr_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_APPEND,
        S_FINISH
    } t_state;

    t_state            r_state, n_state;
    vcqr_pkg::t_status r_status, n_status;
    logic              r_did_deq, n_did_deq;
    logic              r_did_enq, n_did_enq;
    logic              r_out_valid, n_out_valid;
    logic              w_ok;

    // admission check of a commit, evaluated on the pre-step state
    always_comb begin
        if (!i_stat.enq_valid && !i_stat.deq_valid) begin
            w_ok = 1'b0;
        end else if (i_stat.deq_valid && i_stat.empty) begin
            w_ok = 1'b0;
        end else if (!i_stat.enq_valid) begin
            w_ok = 1'b1;
        end else if (i_stat.enq_reserved) begin
            w_ok = !i_stat.full;
        end else if (i_stat.claim_ok) begin
            w_ok = 1'b1;
        end else begin
            w_ok = i_stat.deq_valid && i_stat.swap_ok && i_stat.holds_zero;
        end
    end

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_status    = r_status;
        n_did_deq   = r_did_deq;
        n_did_enq   = r_did_enq;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd.status  = r_status;
        o_cmd.did_deq = r_did_deq;
        o_cmd.did_enq = r_did_enq;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_status      = vcqr_pkg::ST_OK;
                    n_did_deq     = 1'b0;
                    n_did_enq     = 1'b0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FINISH;
                case (i_stat.op)
                    vcqr_pkg::OP_COMMIT: begin
                        if (i_stat.enq_reserved && !i_stat.enq_valid) begin
                            n_status = vcqr_pkg::ST_RSV_NO_ENQ;
                        end else if (!w_ok) begin
                            n_status = vcqr_pkg::ST_CAPACITY;
                        end else if (i_stat.enq_reserved && !i_stat.hold_found) begin
                            n_status = vcqr_pkg::ST_NOT_HELD;
                        end else begin
                            // a consumed reservation stays consumed on a bad dequeue
                            o_cmd.hold_dec = i_stat.enq_reserved;
                            if (i_stat.deq_valid) begin
                                if (!i_stat.offer_match) begin
                                    n_status = vcqr_pkg::ST_NOT_OFFERED;
                                end else begin
                                    o_cmd.deq = 1'b1;
                                    n_did_deq = 1'b1;
                                    n_state   = S_SHIFT;
                                end
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                    end
                    vcqr_pkg::OP_RESERVE: begin
                        if (!i_stat.claim_ok || (!i_stat.hold_found && !i_stat.free_found)) begin
                            n_status = vcqr_pkg::ST_RSV_REFUSED;
                        end else begin
                            o_cmd.hold_inc = 1'b1;
                        end
                    end
                    vcqr_pkg::OP_RELEASE: begin
                        if (!i_stat.hold_found) begin
                            n_status = vcqr_pkg::ST_NOT_HELD;
                        end else begin
                            o_cmd.hold_dec = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                if (i_stat.shift_more) begin
                    o_cmd.shift = 1'b1;
                end else if (i_stat.enq_valid) begin
                    n_state = S_APPEND;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_APPEND: begin
                n_state = S_FINISH;
                if (i_stat.full) begin
                    n_status = vcqr_pkg::ST_TAIL_FULL;
                end else begin
                    o_cmd.append = 1'b1;
                    n_did_enq    = 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= vcqr_pkg::ST_OK;
            r_did_deq   <= 1'b0;
            r_did_enq   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_did_deq   <= n_did_deq;
            r_did_enq   <= n_did_enq;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== hw/rtl/vcqr_dp.sv =====
`timescale 1ns / 1ps
module vcqr_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vcqr_pkg::CFGI_W-1:0]      i_cfg_idx,
    input  logic [vcqr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [vcqr_pkg::IN_TDATA_W-1:0]  i_item_data,
    input  logic [1:0]                       i_item_op,
    input  vcqr_pkg::t_cmd                   i_cmd,
    output vcqr_pkg::t_stat                  o_stat,
    output logic [vcqr_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic [2:0]                       o_out_user
);

    localparam int DEPTH = vcqr_pkg::DEPTH;
    localparam int IDX_W = vcqr_pkg::IDX_W;
    localparam int CNT_W = vcqr_pkg::CNT_W;
    localparam int RC_W  = vcqr_pkg::RC_W;
    localparam int CH_W  = vcqr_pkg::CH_W;

    // configuration
    logic [vcqr_pkg::CFG_W-1:0] r_slots, r_guar;
    logic                       r_swap, r_mode;

    // queue and reservation state
    vcqr_pkg::t_entry  r_store [DEPTH];
    logic [CH_W-1:0]   r_hold_ch [DEPTH];
    logic [CNT_W-1:0]  r_hold_cnt [DEPTH];
    logic [CNT_W-1:0]  r_count, r_hold_total;
    logic [CH_W-1:0]   r_cursor;

    // captured item
    logic [1:0]        r_op;
    logic              r_enqv, r_enqr, r_deqv;
    vcqr_pkg::t_entry  r_enq, r_deq;

    // scan accumulators
    logic [IDX_W-1:0]  r_idx;
    logic              r_res, r_hf, r_ff, r_av, r_bv;
    logic [RC_W-1:0]   r_rc;
    logic [IDX_W-1:0]  r_hidx, r_fidx, r_aidx, r_bidx;
    vcqr_pkg::t_entry  r_a, r_b, r_head, r_removed;

    logic [vcqr_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [2:0]                       r_out_user;

    vcqr_pkg::t_in_data  w_in;
    vcqr_pkg::t_out_data w_out;
    vcqr_pkg::t_entry    w_rd, w_offer, w_rem;
    logic [IDX_W-1:0]    w_rd_idx, w_offer_idx, w_hinc_idx;
    logic [CNT_W-1:0]    w_cap, w_guar;
    logic [CNT_W:0]      w_held, w_free;
    logic [RC_W-1:0]     w_claimed, w_others;
    logic                w_claim_ok, w_e_valid, w_e_dup, w_e_first;
    logic                w_h_live, w_h_dup, w_h_first;
    logic [CH_W-1:0]     w_hc;

    assign w_in = vcqr_pkg::t_in_data'(i_item_data);

    // one read port: current scan element, or the element above during a shift
    assign w_rd_idx = i_cmd.shift ? (r_idx + IDX_W'(1)) : r_idx;
    assign w_rd     = r_store[w_rd_idx];

    always_comb begin
        if (r_slots == '0) begin
            w_cap = CNT_W'(1);
        end else if (CNT_W'(r_slots) > CNT_W'(DEPTH)) begin
            w_cap = CNT_W'(DEPTH);
        end else begin
            w_cap = CNT_W'(r_slots);
        end
        if (!r_mode) begin
            w_guar = '0;
        end else if (CNT_W'(r_guar) > w_cap) begin
            w_guar = w_cap;
        end else begin
            w_guar = CNT_W'(r_guar);
        end
        w_held    = {1'b0, r_count} + {1'b0, r_hold_total};
        w_free    = (w_held < {1'b0, w_cap}) ? ({1'b0, w_cap} - w_held) : '0;
        w_claimed = r_rc + (r_res ? RC_W'(0) : RC_W'(1));
        w_others  = (w_claimed < RC_W'(w_guar)) ? (RC_W'(w_guar) - w_claimed) : '0;
        if (w_guar == '0) begin
            w_claim_ok = (w_free != '0);
        end else begin
            w_claim_ok = (RC_W'(w_free) > w_others);
        end
    end

    // first-occurrence test for distinct resident channels, entries before holds
    always_comb begin
        w_e_valid = (CNT_W'(r_idx) < r_count);
        w_h_live  = (r_hold_cnt[r_idx] != '0);
        w_hc      = r_hold_ch[r_idx];
        w_e_dup   = 1'b0;
        w_h_dup   = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (IDX_W'(k) < r_idx && r_store[k].ch == w_rd.ch) begin
                w_e_dup = 1'b1;
            end
            if (CNT_W'(k) < r_count && r_store[k].ch == w_hc) begin
                w_h_dup = 1'b1;
            end
            if (IDX_W'(k) < r_idx && r_hold_cnt[k] != '0 && r_hold_ch[k] == w_hc) begin
                w_h_dup = 1'b1;
            end
        end
        w_e_first = w_e_valid && !w_e_dup;
        w_h_first = w_h_live && !w_h_dup;
    end

    always_comb begin
        if (r_mode) begin
            w_offer     = r_av ? r_a : r_b;
            w_offer_idx = r_av ? r_aidx : r_bidx;
        end else begin
            w_offer     = r_head;
            w_offer_idx = '0;
        end
        w_hinc_idx = r_hf ? r_hidx : r_fidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots      <= vcqr_pkg::CFG_W'(DEPTH);
            r_swap       <= 1'b0;
            r_mode       <= 1'b0;
            r_guar       <= '0;
            r_count      <= '0;
            r_hold_total <= '0;
            r_cursor     <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_hold_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vcqr_pkg::CFG_SLOTS: r_slots <= i_cfg_data;
                    vcqr_pkg::CFG_SWAP:  r_swap  <= i_cfg_data[0];
                    vcqr_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    vcqr_pkg::CFG_GUAR:  r_guar  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.hold_dec) begin
                r_hold_cnt[r_hidx] <= r_hold_cnt[r_hidx] - CNT_W'(1);
                r_hold_total       <= r_hold_total - CNT_W'(1);
            end
            if (i_cmd.hold_inc) begin
                r_hold_cnt[w_hinc_idx] <= r_hold_cnt[w_hinc_idx] + CNT_W'(1);
                r_hold_total           <= r_hold_total + CNT_W'(1);
            end
            if (i_cmd.deq) begin
                r_cursor <= w_offer.ch + CH_W'(1);
                r_count  <= r_count - CNT_W'(1);
            end
            if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_item_op;
            r_enqv  <= w_in.enq_valid;
            r_enqr  <= w_in.enq_reserved;
            r_deqv  <= w_in.deq_valid;
            r_enq   <= '{ch: w_in.channel, tag: w_in.enq_tag, node: w_in.enq_node,
                         slot: w_in.enq_slot};
            r_deq   <= '{ch: w_in.deq_channel, tag: w_in.deq_tag, node: w_in.deq_node,
                         slot: w_in.deq_slot};
            r_idx   <= '0;
            r_res   <= 1'b0;
            r_rc    <= '0;
            r_hf    <= 1'b0;
            r_ff    <= 1'b0;
            r_av    <= 1'b0;
            r_bv    <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + IDX_W'(1);
            r_rc  <= r_rc + RC_W'(w_e_first) + RC_W'(w_h_first);
            if ((w_e_valid && w_rd.ch == r_enq.ch) || (w_h_live && w_hc == r_enq.ch)) begin
                r_res <= 1'b1;
            end
            if (!r_hf && w_h_live && w_hc == r_enq.ch) begin
                r_hf   <= 1'b1;
                r_hidx <= r_idx;
            end
            if (!r_ff && !w_h_live) begin
                r_ff   <= 1'b1;
                r_fidx <= r_idx;
            end
            if (r_idx == '0) begin
                r_head <= w_rd;
            end
            // lowest channel at or after the cursor, else lowest below it; oldest wins ties
            if (w_e_valid) begin
                if (w_rd.ch >= r_cursor) begin
                    if (!r_av || w_rd.ch < r_a.ch) begin
                        r_av   <= 1'b1;
                        r_a    <= w_rd;
                        r_aidx <= r_idx;
                    end
                end else if (!r_bv || w_rd.ch < r_b.ch) begin
                    r_bv   <= 1'b1;
                    r_b    <= w_rd;
                    r_bidx <= r_idx;
                end
            end
        end
        if (i_cmd.hold_inc && !r_hf) begin
            r_hold_ch[r_fidx] <= r_enq.ch;
        end
        if (i_cmd.deq) begin
            r_removed <= w_offer;
            r_idx     <= w_offer_idx;
        end
        if (i_cmd.shift) begin
            r_store[r_idx] <= w_rd;
            r_idx          <= r_idx + IDX_W'(1);
        end
        if (i_cmd.append) begin
            r_store[r_count[IDX_W-1:0]] <= r_enq;
        end
        if (i_cmd.load_out) begin
            r_out_data <= w_out;
            r_out_user <= i_cmd.status;
        end
    end

    always_comb begin
        w_rem                = i_cmd.did_deq ? r_removed : '0;
        w_out                = '0;
        w_out.dequeued_valid = i_cmd.did_deq;
        w_out.out_slot       = w_rem.slot;
        w_out.out_node       = w_rem.node;
        w_out.out_tag        = w_rem.tag;
        w_out.out_channel    = w_rem.ch;
        w_out.enqueued       = i_cmd.did_enq;
        w_out.occupancy      = r_count;
        w_out.reserved_total = r_hold_total;
    end

    always_comb begin
        o_stat              = '0;
        o_stat.op           = r_op;
        o_stat.enq_valid    = r_enqv;
        o_stat.enq_reserved = r_enqr;
        o_stat.deq_valid    = r_deqv;
        o_stat.scan_last    = (r_idx == IDX_W'(DEPTH - 1));
        o_stat.empty        = (r_count == '0);
        o_stat.full         = (r_count >= w_cap);
        o_stat.claim_ok     = w_claim_ok;
        o_stat.hold_found   = r_hf;
        o_stat.free_found   = r_ff;
        o_stat.offer_match  = (r_count != '0) && (w_offer == r_deq);
        o_stat.holds_zero   = (r_hold_total == '0);
        o_stat.swap_ok      = r_swap;
        o_stat.shift_more   = (CNT_W'(r_idx) < r_count);
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

endmodule

// ===== hw/rtl/virtual_channel_queue_reserve.sv =====
`timescale 1ns / 1ps
// Virtual channel queue with slot reservations. One item is handled at a time: an accepted
// beat is first scanned over all 16 entry and reservation positions, one position a cycle
// (offer search, channel residency and distinct-channel count), then decided. A dequeue closes
// the gap in the buffer by moving the younger entries down one per cycle, then an enqueue
// appends the new entry, and the result is loaded into the output register. A stalled output
// register keeps the item waiting until it is free. A new beat is taken once the previous
// result is in the output register. Configuration writes apply at once and are meant for idle
// periods.
module virtual_channel_queue_reserve (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vcqr_pkg::CFGI_W-1:0]       i_cfg_idx,
    input  logic [vcqr_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // enq_valid, enq_reserved, channel, enq_slot, enq_node, enq_tag, deq_valid,
    // deq_slot, deq_node, deq_tag, deq_channel, zero pad
    input  logic [vcqr_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // op
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // dequeued_valid, out_slot, out_node, out_tag, out_channel, enqueued,
    // occupancy, reserved_total, zero pad
    output logic [vcqr_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // status
    output logic [2:0]                        o_m_tuser
);

    vcqr_pkg::t_cmd  w_cmd;
    vcqr_pkg::t_stat w_stat;

    vcqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    vcqr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_item_data (i_s_tdata),
        .i_item_op   (i_s_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

endmodule

// ===== hw/rtl/vcqr_checker.sv =====
`timescale 1ns / 1ps
`include "virtual_channel_queue_reserve_defines.svh"
module vcqr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [vcqr_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [2:0]                        o_m_tuser
);

    vcqr_pkg::t_out_data w_out;
    assign w_out = vcqr_pkg::t_out_data'(o_m_tdata);

    `VCQR_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result beat dropped")
    `VCQR_ASSERT_NEXT(a_one_item, i_s_tvalid && o_s_tready, !o_s_tready, "second beat taken")
    `VCQR_ASSERT_NOW(a_no_deq_zero, o_m_tvalid && !w_out.dequeued_valid,
        w_out.out_slot == '0 && w_out.out_node == '0
        && w_out.out_tag == '0 && w_out.out_channel == '0,
        "removed fields not cleared")
    `VCQR_ASSERT_NOW(a_enq_ok, o_m_tvalid && w_out.enqueued, o_m_tuser == vcqr_pkg::ST_OK,
        "enqueue with error status")
    `VCQR_ASSERT_NOW(a_occ_range, o_m_tvalid,
        w_out.occupancy <= vcqr_pkg::CNT_W'(vcqr_pkg::DEPTH)
        && w_out.reserved_total <= vcqr_pkg::CNT_W'(vcqr_pkg::DEPTH),
        "occupancy or reservations above depth")

endmodule

bind virtual_channel_queue_reserve vcqr_checker u_vcqr_checker (.*);
